// ===== design/jtsrs_pkg.sv =====
// Package for the TMS shift-region splitter: TAP state codes, the TAP
// next-state function, shared item and flag types. No dependencies.
package jtsrs_pkg;

  // Default width of a bit position within one sequence.
  localparam int POS_BITS_DEF = 16;

  typedef logic [3:0] tap_state_t;

  // TAP controller states, in the usual encoding order.
  localparam tap_state_t ST_TEST_LOGIC_RESET = 4'd0;
  localparam tap_state_t ST_RUN_TEST_IDLE    = 4'd1;
  localparam tap_state_t ST_SELECT_DR        = 4'd2;
  localparam tap_state_t ST_CAPTURE_DR       = 4'd3;
  localparam tap_state_t ST_SHIFT_DR         = 4'd4;
  localparam tap_state_t ST_EXIT1_DR         = 4'd5;
  localparam tap_state_t ST_PAUSE_DR         = 4'd6;
  localparam tap_state_t ST_EXIT2_DR         = 4'd7;
  localparam tap_state_t ST_UPDATE_DR        = 4'd8;
  localparam tap_state_t ST_SELECT_IR        = 4'd9;
  localparam tap_state_t ST_CAPTURE_IR       = 4'd10;
  localparam tap_state_t ST_SHIFT_IR         = 4'd11;
  localparam tap_state_t ST_EXIT1_IR         = 4'd12;
  localparam tap_state_t ST_PAUSE_IR         = 4'd13;
  localparam tap_state_t ST_EXIT2_IR         = 4'd14;
  localparam tap_state_t ST_UPDATE_IR        = 4'd15;

  // One input item as held in the input register.
  typedef struct packed {
    logic       tms_bit;
    logic       first_bit;
    logic       last_bit;
    tap_state_t start_state;
  } in_item_t;

  // Flag part of one result item; positions travel alongside.
  typedef struct packed {
    logic       region_is_tms;
    logic       region_flip_tms;
    tap_state_t final_state;
    logic       last_region;
  } region_flags_t;

  // True for the two shift states.
  function automatic logic is_shift(input tap_state_t s);
    return (s == ST_SHIFT_DR) || (s == ST_SHIFT_IR);
  endfunction

  // Standard TAP state transition on one TMS bit.
  function automatic tap_state_t tap_step(input tap_state_t cur, input logic tms);
    tap_state_t nxt;
    nxt = ST_TEST_LOGIC_RESET;
    case (cur)
      ST_TEST_LOGIC_RESET: nxt = tms ? ST_TEST_LOGIC_RESET : ST_RUN_TEST_IDLE;
      ST_RUN_TEST_IDLE:    nxt = tms ? ST_SELECT_DR        : ST_RUN_TEST_IDLE;
      ST_SELECT_DR:        nxt = tms ? ST_SELECT_IR        : ST_CAPTURE_DR;
      ST_CAPTURE_DR:       nxt = tms ? ST_EXIT1_DR         : ST_SHIFT_DR;
      ST_SHIFT_DR:         nxt = tms ? ST_EXIT1_DR         : ST_SHIFT_DR;
      ST_EXIT1_DR:         nxt = tms ? ST_UPDATE_DR        : ST_PAUSE_DR;
      ST_PAUSE_DR:         nxt = tms ? ST_EXIT2_DR         : ST_PAUSE_DR;
      ST_EXIT2_DR:         nxt = tms ? ST_UPDATE_DR        : ST_SHIFT_DR;
      ST_UPDATE_DR:        nxt = tms ? ST_SELECT_DR        : ST_RUN_TEST_IDLE;
      ST_SELECT_IR:        nxt = tms ? ST_TEST_LOGIC_RESET : ST_CAPTURE_IR;
      ST_CAPTURE_IR:       nxt = tms ? ST_EXIT1_IR         : ST_SHIFT_IR;
      ST_SHIFT_IR:         nxt = tms ? ST_EXIT1_IR         : ST_SHIFT_IR;
      ST_EXIT1_IR:         nxt = tms ? ST_UPDATE_IR        : ST_PAUSE_IR;
      ST_PAUSE_IR:         nxt = tms ? ST_EXIT2_IR         : ST_PAUSE_IR;
      ST_EXIT2_IR:         nxt = tms ? ST_UPDATE_IR        : ST_SHIFT_IR;
      ST_UPDATE_IR:        nxt = tms ? ST_SELECT_DR        : ST_RUN_TEST_IDLE;
      default:             nxt = ST_TEST_LOGIC_RESET;
    endcase
    return nxt;
  endfunction

endpackage

// ===== design/jtsrs_in_if.sv =====
// Input channel of the TMS shift-region splitter: valid/ready plus one TMS bit item.
// Depends on nothing.
interface jtsrs_in_if;
  logic       valid;
  logic       ready;
  logic       tms_bit;
  logic       first_bit;
  logic       last_bit;
  logic [3:0] start_state;

  modport source (output valid, output tms_bit, output first_bit,
                  output last_bit, output start_state, input ready);
  modport sink   (input valid, input tms_bit, input first_bit,
                  input last_bit, input start_state, output ready);
endinterface

// ===== design/jtsrs_out_if.sv =====
// Result channel of the TMS shift-region splitter: valid/ready plus one region item.
// Depends on jtsrs_pkg for the default position width.
interface jtsrs_out_if #(
  parameter int POS_BITS = jtsrs_pkg::POS_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                region_is_tms;
  logic                region_flip_tms;
  logic [POS_BITS-1:0] region_begin;
  logic [POS_BITS:0]   region_end;
  logic [3:0]          final_state;
  logic                last_region;

  modport source (output valid, output region_is_tms, output region_flip_tms,
                  output region_begin, output region_end, output final_state,
                  output last_region, input ready);
  modport sink   (input valid, input region_is_tms, input region_flip_tms,
                  input region_begin, input region_end, input final_state,
                  input last_region, output ready);
endinterface

// ===== design/jtag_tms_shift_region_splitter_core.sv =====
// TMS shift-region splitter. Takes one TMS bit per item and steps the JTAG TAP
// controller; an item enters the input register and its region, if any, is
// decided from there and written to the result register once that register is
// free or draining. The block takes one item every cycle while the result side
// does not stall; a single TAP table step per bit lies between the two
// registers, and a stall on the result side holds the input register. Items that
// cause no region leave nothing on the result channel. Depends on jtsrs_pkg,
// jtsrs_in_if, jtsrs_out_if and jtsrs_region_logic.
module jtag_tms_shift_region_splitter_core #(
  parameter int POS_BITS = jtsrs_pkg::POS_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  jtsrs_in_if.sink    in_if,
  jtsrs_out_if.source out_if
);

  logic                     s1_valid_r, s1_valid_nxt;
  jtsrs_pkg::in_item_t      s1_item_r;
  logic                     s1_go;

  logic                     has_region;
  jtsrs_pkg::region_flags_t flags;
  logic [POS_BITS-1:0]      region_begin;
  logic [POS_BITS:0]        region_end;

  logic                     out_valid_r, out_valid_nxt;
  jtsrs_pkg::region_flags_t out_flags_r;
  logic [POS_BITS-1:0]      out_begin_r;
  logic [POS_BITS:0]        out_end_r;

  // The held item moves on whenever the result register is free or draining.
  assign s1_go       = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_go;

  // Input register.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_if.valid && in_if.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_item_r.tms_bit     <= in_if.tms_bit;
      s1_item_r.first_bit   <= in_if.first_bit;
      s1_item_r.last_bit    <= in_if.last_bit;
      s1_item_r.start_state <= in_if.start_state;
    end
  end

  // Sequence state and region decision.
  jtsrs_region_logic #(
    .POS_BITS (POS_BITS)
  ) u_region (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_go),
    .item         (s1_item_r),
    .has_region   (has_region),
    .flags        (flags),
    .region_begin (region_begin),
    .region_end   (region_end)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = has_region;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_region) begin
      out_flags_r <= flags;
      out_begin_r <= region_begin;
      out_end_r   <= region_end;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.region_is_tms   = out_flags_r.region_is_tms;
  assign out_if.region_flip_tms = out_flags_r.region_flip_tms;
  assign out_if.region_begin    = out_begin_r;
  assign out_if.region_end      = out_end_r;
  assign out_if.final_state     = out_flags_r.final_state;
  assign out_if.last_region     = out_flags_r.last_region;

endmodule

// ===== design/jtsrs_region_logic.sv =====
// Sequence state (TAP state, bit position, open region start) and the
// per-bit region decision. Depends on jtsrs_pkg.
module jtsrs_region_logic #(
  parameter int POS_BITS = jtsrs_pkg::POS_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  jtsrs_pkg::in_item_t      item,
  output logic                     has_region,
  output jtsrs_pkg::region_flags_t flags,
  output logic [POS_BITS-1:0]      region_begin,
  output logic [POS_BITS:0]        region_end
);

  jtsrs_pkg::tap_state_t tap_state_r, tap_state_nxt;
  logic [POS_BITS:0]     bit_pos_r, bit_pos_nxt;
  logic [POS_BITS:0]     region_start_r, region_start_nxt;

  jtsrs_pkg::tap_state_t cur, nxt;
  logic [POS_BITS:0]     pos, start, here;
  logic                  entry, leave;

  // A first bit restarts the sequence from the supplied TAP state.
  always_comb begin
    cur   = item.first_bit ? item.start_state : tap_state_r;
    pos   = item.first_bit ? '0 : bit_pos_r;
    start = item.first_bit ? '0 : region_start_r;
    nxt   = jtsrs_pkg::tap_step(cur, item.tms_bit);
    // Position saturates once the top bit is reached.
    here  = pos[POS_BITS] ? pos : pos + {{POS_BITS{1'b0}}, 1'b1};
    entry = !jtsrs_pkg::is_shift(cur) && jtsrs_pkg::is_shift(nxt);
    leave = jtsrs_pkg::is_shift(cur) && !jtsrs_pkg::is_shift(nxt);
  end

  // Region emitted on entry to or exit from a shift state, or as the tail.
  always_comb begin
    has_region            = entry || leave || item.last_bit;
    flags.region_is_tms   = entry ? 1'b1 : (leave ? 1'b0 : !jtsrs_pkg::is_shift(nxt));
    flags.region_flip_tms = leave;
    flags.final_state     = nxt;
    flags.last_region     = item.last_bit;
    region_begin          = start[POS_BITS] ? {POS_BITS{1'b1}} : start[POS_BITS-1:0];
    region_end            = here;
  end

  // State after this bit; the last bit of a sequence rewinds the positions.
  always_comb begin
    tap_state_nxt    = nxt;
    bit_pos_nxt      = item.last_bit ? '0 : here;
    region_start_nxt = item.last_bit ? '0 : ((entry || leave) ? here : start);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_state_r    <= jtsrs_pkg::ST_TEST_LOGIC_RESET;
      bit_pos_r      <= '0;
      region_start_r <= '0;
    end else if (step) begin
      tap_state_r    <= tap_state_nxt;
      bit_pos_r      <= bit_pos_nxt;
      region_start_r <= region_start_nxt;
    end
  end

endmodule

// ===== design/jtsrs_checker.sv =====
// Port-level checks for the TMS shift-region splitter, bound to the top level.
// Depends on jtsrs_pkg and jtag_tms_shift_region_splitter_core.
module jtsrs_checker #(
  parameter int POS_BITS = jtsrs_pkg::POS_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                region_is_tms,
  input logic                region_flip_tms,
  input logic [POS_BITS-1:0] region_begin,
  input logic [POS_BITS:0]   region_end,
  input logic [3:0]          final_state,
  input logic                last_region
);

  logic ends_in_shift;
  assign ends_in_shift = (final_state == jtsrs_pkg::ST_SHIFT_DR) ||
                         (final_state == jtsrs_pkg::ST_SHIFT_IR);

  // A stalled item holds its whole payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({region_is_tms, region_flip_tms, region_begin, region_end,
               final_state, last_region}))
    else $error("result item changed while stalled");

  // Every region covers at least one position.
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> region_end > {1'b0, region_begin})
    else $error("region end not beyond its begin");

  // An exit region is a TDI region and leaves the shift states.
  a_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && region_flip_tms |-> !region_is_tms && !ends_in_shift)
    else $error("bad exit region");

  // A TDI region without flip is only ever a tail ending in a shift state.
  a_tdi_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !region_is_tms && !region_flip_tms |-> last_region && ends_in_shift)
    else $error("bad TDI tail region");

  // A TMS region that is not the last one is an entry into a shift state.
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && region_is_tms && !last_region |-> ends_in_shift && !region_flip_tms)
    else $error("bad entry region");

endmodule

bind jtag_tms_shift_region_splitter_core jtsrs_checker #(
  .POS_BITS (POS_BITS)
) u_jtsrs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .region_is_tms   (out_if.region_is_tms),
  .region_flip_tms (out_if.region_flip_tms),
  .region_begin    (out_if.region_begin),
  .region_end      (out_if.region_end),
  .final_state     (out_if.final_state),
  .last_region     (out_if.last_region)
);
